// File: hdl/tvps_pkg.sv
package tvps_pkg;

	localparam int COORD_W = 16;
	localparam int TRIG_F  = 14;
	localparam int REG_W   = 16;
	localparam int OUT_W   = 17;
	localparam int SHADE_W = 16;
	localparam int NRM_W   = 35;
	localparam int W_W     = 18;

	localparam logic [SHADE_W-1:0] SHADE_BASE = 16'd8192;
	localparam logic [SHADE_W-1:0] SHADE_SPAN = 16'd24576;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;

	// register indexes on the APB port (word address)
	localparam logic [1:0] REG_COS_AZ = 2'd0;
	localparam logic [1:0] REG_SIN_AZ = 2'd1;
	localparam logic [1:0] REG_COS_EL = 2'd2;
	localparam logic [1:0] REG_SIN_EL = 2'd3;

	typedef struct packed {
		logic [REG_W-1:0] ca;
		logic [REG_W-1:0] sa;
		logic [REG_W-1:0] ce;
		logic [REG_W-1:0] se;
	} trig_t;

	typedef struct packed {
		logic [OUT_W-1:0]       mean;
		logic [2:0][OUT_W-1:0]  v;
		logic [2:0][OUT_W-1:0]  u;
	} pay_t;

	typedef struct packed {
		pay_t                   pay;
		logic [2:0][NRM_W-1:0]  nrm;
		logic [W_W-1:0]         w0;
		logic [W_W-1:0]         w1;
		logic [REG_W-1:0]       w2;
	} tri_t;

	// shift right by TRIG_F, round to nearest, ties away from zero
	function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] s);
		logic [63:0] mag;
		logic [63:0] m;
		mag = s[63] ? 64'(-s) : 64'(s);
		m = (mag + (64'd1 << (TRIG_F - 1))) >> TRIG_F;
		return s[63] ? -$signed(m) : $signed(m);
	endfunction

	function automatic logic [OUT_W-1:0] sat_out(input logic signed [63:0] s);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = (64'sd1 <<< (OUT_W - 1)) - 64'sd1;
		lo = -(64'sd1 <<< (OUT_W - 1));
		if (s > hi)
			return hi[OUT_W-1:0];
		else if (s < lo)
			return lo[OUT_W-1:0];
		else
			return s[OUT_W-1:0];
	endfunction

endpackage

// File: hdl/tvps_front.sv
module tvps_front import tvps_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  trig_t                     trig,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [8:0][COORD_W-1:0]   crd,
	output logic                      push,
	input  logic                      full,
	output tri_t                      tri_out
);

	logic en;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;

	logic signed [REG_W-1:0] ca, sa, ce, se;

	logic signed [COORD_W-1:0] crd_s1 [9];
	logic signed [32:0]        pt_s2 [3];
	logic signed [32:0]        pu_s2 [3];
	logic signed [COORD_W-1:0] z_s2 [3];
	logic signed [16:0]        e1_s2 [3];
	logic signed [16:0]        e2_s2 [3];
	logic signed [31:0]        wa_s2, wb_s2;
	logic signed [19:0]        t_s3 [3];
	logic signed [19:0]        u_s3 [3];
	logic signed [COORD_W-1:0] z_s3 [3];
	logic signed [33:0]        np_s3 [6];
	logic [W_W-1:0]            w0_s3, w1_s3;
	logic signed [36:0]        pv_s4 [3];
	logic signed [36:0]        pd_s4 [3];
	tri_t                      tr_s4, tr_s5, tr_s6, tr_s7, tr_s8;
	logic signed [23:0]        v_s5 [3];
	logic signed [23:0]        d_s5 [3];
	logic signed [25:0]        ds_s6;
	logic                      neg_s7;
	logic [57:0]               prd_s7;

	logic [25:0]        dmag;
	logic signed [63:0] qs;
	tri_t               tr6_d, tr8_d;

	assign ca = trig.ca;
	assign sa = trig.sa;
	assign ce = trig.ce;
	assign se = trig.se;

	assign en       = !vld_s8 || !full;
	assign in_ready = en;
	assign push     = vld_s8 && !full;
	assign tri_out  = tr_s8;

	always_comb begin
		dmag = ds_s6[25] ? 26'(-ds_s6) : 26'(ds_s6);
		qs   = $signed(64'(prd_s7[57:33]));

		tr6_d = tr_s5;
		for (int k = 0; k < 3; k++)
			tr6_d.pay.v[k] = sat_out(64'(v_s5[k]));

		tr8_d          = tr_s7;
		tr8_d.pay.mean = sat_out(neg_s7 ? -qs : qs);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 9; i++)
				crd_s1[i] <= $signed(crd[i]);

			// rotate about z by azimuth, edges for the normal
			for (int k = 0; k < 3; k++) begin
				pt_s2[k] <= 33'(crd_s1[3*k]) * 33'(ca) + 33'(crd_s1[3*k+1]) * 33'(sa);
				pu_s2[k] <= 33'(crd_s1[3*k+1]) * 33'(ca) - 33'(crd_s1[3*k]) * 33'(sa);
				z_s2[k]  <= crd_s1[3*k+2];
				e1_s2[k] <= 17'(crd_s1[3+k]) - 17'(crd_s1[k]);
				e2_s2[k] <= 17'(crd_s1[6+k]) - 17'(crd_s1[k]);
			end
			wa_s2 <= 32'(ca) * 32'(ce);
			wb_s2 <= 32'(sa) * 32'(ce);

			for (int k = 0; k < 3; k++) begin
				t_s3[k] <= 20'(rnd_shift(64'(pt_s2[k])));
				u_s3[k] <= 20'(rnd_shift(64'(pu_s2[k])));
				z_s3[k] <= z_s2[k];
			end
			np_s3[0] <= 34'(e1_s2[1]) * 34'(e2_s2[2]);
			np_s3[1] <= 34'(e1_s2[2]) * 34'(e2_s2[1]);
			np_s3[2] <= 34'(e1_s2[2]) * 34'(e2_s2[0]);
			np_s3[3] <= 34'(e1_s2[0]) * 34'(e2_s2[2]);
			np_s3[4] <= 34'(e1_s2[0]) * 34'(e2_s2[1]);
			np_s3[5] <= 34'(e1_s2[1]) * 34'(e2_s2[0]);
			w0_s3 <= W_W'(rnd_shift(64'(wa_s2)));
			w1_s3 <= W_W'(rnd_shift(64'(wb_s2)));

			// tilt by elevation
			for (int k = 0; k < 3; k++) begin
				pv_s4[k] <= 37'(z_s3[k]) * 37'(ce) - 37'(t_s3[k]) * 37'(se);
				pd_s4[k] <= 37'(t_s3[k]) * 37'(ce) + 37'(z_s3[k]) * 37'(se);
				tr_s4.pay.u[k] <= sat_out(64'(u_s3[k]));
				tr_s4.nrm[k]   <= 35'(np_s3[2*k]) - 35'(np_s3[2*k+1]);
			end
			tr_s4.pay.v    <= '0;
			tr_s4.pay.mean <= '0;
			tr_s4.w0       <= w0_s3;
			tr_s4.w1       <= w1_s3;
			tr_s4.w2       <= se;

			tr_s5 <= tr_s4;
			for (int k = 0; k < 3; k++) begin
				v_s5[k] <= 24'(rnd_shift(64'(pv_s4[k])));
				d_s5[k] <= 24'(rnd_shift(64'(pd_s4[k])));
			end

			tr_s6 <= tr6_d;
			ds_s6 <= 26'(d_s5[0]) + 26'(d_s5[1]) + 26'(d_s5[2]);

			// mean = floor((|sum| + 1) / 3), reciprocal multiply
			tr_s7  <= tr_s6;
			neg_s7 <= ds_s6[25];
			prd_s7 <= 58'(dmag + 26'd1) * 58'(32'hAAAAAAAB);

			tr_s8 <= tr8_d;
		end
	end

endmodule

// File: hdl/tvps_fifo.sv
module tvps_fifo import tvps_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  tri_t wdata,
	output logic full,
	input  logic pop,
	output tri_t rdata,
	output logic empty
);

	tri_t               mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wp_q, rp_q;
	logic [FIFO_AW:0]   cnt_q;

	assign full  = cnt_q == FIFO_AW'(0) + (FIFO_AW+1)'(FIFO_DEPTH);
	assign empty = cnt_q == '0;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= wp_q + 1'b1;
			if (pop)
				rp_q <= rp_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= wdata;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("fifo push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("fifo pop while empty");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1) else $error("fifo count slip");

endmodule

// File: hdl/tvps_back.sv
module tvps_back import tvps_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  tri_t               in_tri,
	output logic               out_valid,
	input  logic               out_ready,
	output pay_t               out_pay,
	output logic [SHADE_W-1:0] out_shade
);

	localparam int P_MAG = 0;
	localparam int P_MAX = 1;
	localparam int P_POS = 2;
	localparam int P_SHF = 3;
	localparam int P_MUL = 4;
	localparam int P_SUM = 5;
	localparam int P_SQ0 = 6;
	localparam int SQ_N  = 32;
	localparam int P_ND  = P_SQ0 + SQ_N + 1;
	localparam int P_OV  = P_ND + 1;
	localparam int DV_N  = 15;
	localparam int P_OUT = P_OV + DV_N + 1;
	localparam int NB    = P_OUT + 1;

	typedef struct packed {
		pay_t             pay;
		logic [2:0]       neg;
		logic             deg;
		logic [W_W-1:0]   w0;
		logic [W_W-1:0]   w1;
		logic [REG_W-1:0] w2;
		logic [49:0]      anum;
	} ctx_t;

	logic          en;
	logic [NB-1:0] vld_q;
	ctx_t          ctx_q [NB];

	logic [33:0]        mg_s1 [3];
	logic [33:0]        mg_s2 [3];
	logic [33:0]        mx_s2;
	logic [33:0]        mg_s3 [3];
	logic [5:0]         pos_s3;
	logic [29:0]        ms_s4 [3];
	logic signed [48:0] pr_s5 [3];
	logic [59:0]        sq_s5 [3];
	logic signed [50:0] num_s6;
	logic [61:0]        n2_s6;
	logic [63:0]        sqn_q [SQ_N+1];
	logic [63:0]        sqr_q [SQ_N+1];
	logic [67:0]        nn_q, dd_q;
	logic [67:0]        rem_q [DV_N+1];
	logic [67:0]        dv_q [DV_N+1];
	logic [DV_N-1:0]    qb_q [DV_N+1];
	logic               ovf_q [DV_N+1];
	logic [SHADE_W-1:0] sh_q;

	logic signed [NRM_W-1:0] nin [3];
	logic [33:0]             amg [3];
	logic [33:0]             mx;
	logic [5:0]              pos;
	logic [29:0]             shd [3];
	logic signed [W_W-1:0]   wv [3];
	logic signed [48:0]      prd [3];
	logic [49:0]             anum;
	logic [63:0]             sqn_d [SQ_N];
	logic [63:0]             sqr_d [SQ_N];
	logic [63:0]             trial [SQ_N];
	logic [67:0]             rem_d [DV_N];
	logic [DV_N-1:0]         qb_d [DV_N];
	logic [67:0]             dsh [DV_N];
	logic [SHADE_W-1:0]      qfin;
	ctx_t                    ctx_pos, ctx_sq0;

	assign en        = !vld_q[NB-1] || out_ready;
	assign in_ready  = en;
	assign out_valid = vld_q[NB-1];
	assign out_pay   = ctx_q[NB-1].pay;
	assign out_shade = sh_q;

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			nin[j] = $signed(in_tri.nrm[j]);
			amg[j] = nin[j][NRM_W-1] ? 34'(-nin[j]) : 34'(nin[j]);
		end

		mx = mg_s1[0];
		if (mg_s1[1] > mx)
			mx = mg_s1[1];
		if (mg_s1[2] > mx)
			mx = mg_s1[2];

		pos = '0;
		for (int i = 0; i < 34; i++)
			if (mx_s2[i])
				pos = 6'(i);

		// bring the largest magnitude into [2^29, 2^30)
		for (int j = 0; j < 3; j++) begin
			if (pos_s3 >= 6'd29)
				shd[j] = 30'(mg_s3[j] >> (pos_s3 - 6'd29));
			else
				shd[j] = 30'(mg_s3[j] << (6'd29 - pos_s3));
		end

		wv[0] = $signed(ctx_q[P_SHF].w0);
		wv[1] = $signed(ctx_q[P_SHF].w1);
		wv[2] = W_W'($signed(ctx_q[P_SHF].w2));
		for (int j = 0; j < 3; j++)
			prd[j] = 49'($signed({1'b0, ms_s4[j]})) * 49'(wv[j]);

		anum = num_s6[50] ? 50'(-num_s6) : 50'(num_s6);

		// one result bit per stage
		for (int i = 0; i < SQ_N; i++) begin
			trial[i] = sqr_q[i] + (64'd1 << (62 - 2 * i));
			if (sqn_q[i] >= trial[i]) begin
				sqn_d[i] = sqn_q[i] - trial[i];
				sqr_d[i] = (sqr_q[i] >> 1) + (64'd1 << (62 - 2 * i));
			end else begin
				sqn_d[i] = sqn_q[i];
				sqr_d[i] = sqr_q[i] >> 1;
			end
		end

		// restoring division, quotient bit DV_N-1-i in stage i
		for (int i = 0; i < DV_N; i++) begin
			dsh[i] = dv_q[i] << (DV_N - 1 - i);
			if (rem_q[i] >= dsh[i]) begin
				rem_d[i] = rem_q[i] - dsh[i];
				qb_d[i]  = qb_q[i] | (DV_N'(1) << (DV_N - 1 - i));
			end else begin
				rem_d[i] = rem_q[i];
				qb_d[i]  = qb_q[i];
			end
		end

		if (ctx_q[P_OUT-1].deg)
			qfin = '0;
		else if (ovf_q[DV_N] || SHADE_W'(qb_q[DV_N]) > SHADE_SPAN)
			qfin = SHADE_SPAN;
		else
			qfin = SHADE_W'(qb_q[DV_N]);

		ctx_pos     = ctx_q[P_POS-1];
		ctx_pos.deg = mx_s2 == '0;
		ctx_sq0      = ctx_q[P_SQ0-1];
		ctx_sq0.anum = anum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[NB-2:0], in_valid};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_q[P_MAG].pay  <= in_tri.pay;
			ctx_q[P_MAG].neg  <= {in_tri.nrm[2][NRM_W-1], in_tri.nrm[1][NRM_W-1],
				in_tri.nrm[0][NRM_W-1]};
			ctx_q[P_MAG].deg  <= 1'b0;
			ctx_q[P_MAG].w0   <= in_tri.w0;
			ctx_q[P_MAG].w1   <= in_tri.w1;
			ctx_q[P_MAG].w2   <= in_tri.w2;
			ctx_q[P_MAG].anum <= '0;
			for (int i = 1; i < NB; i++) begin
				if (i == P_POS)
					ctx_q[i] <= ctx_pos;
				else if (i == P_SQ0)
					ctx_q[i] <= ctx_sq0;
				else
					ctx_q[i] <= ctx_q[i-1];
			end

			for (int j = 0; j < 3; j++) begin
				mg_s1[j] <= amg[j];
				mg_s2[j] <= mg_s1[j];
				mg_s3[j] <= mg_s2[j];
				ms_s4[j] <= shd[j];
				pr_s5[j] <= ctx_q[P_SHF].neg[j] ? -prd[j] : prd[j];
				sq_s5[j] <= 60'(ms_s4[j]) * 60'(ms_s4[j]);
			end
			mx_s2  <= mx;
			pos_s3 <= pos;

			num_s6 <= 51'(pr_s5[0]) + 51'(pr_s5[1]) + 51'(pr_s5[2]);
			n2_s6  <= 62'(sq_s5[0]) + 62'(sq_s5[1]) + 62'(sq_s5[2]);

			sqn_q[0] <= 64'(n2_s6);
			sqr_q[0] <= '0;
			for (int i = 0; i < SQ_N; i++) begin
				sqn_q[i+1] <= sqn_d[i];
				sqr_q[i+1] <= sqr_d[i];
			end

			// N = 2*span*|num| + den, D = 2*den, den = r << F
			nn_q <= (68'(ctx_q[P_ND-1].anum) << 15) + (68'(ctx_q[P_ND-1].anum) << 14)
				+ (68'(sqr_q[SQ_N]) << TRIG_F);
			dd_q <= 68'(sqr_q[SQ_N]) << (TRIG_F + 1);

			rem_q[0] <= nn_q;
			dv_q[0]  <= dd_q;
			qb_q[0]  <= '0;
			ovf_q[0] <= nn_q >= (dd_q << DV_N);
			for (int i = 0; i < DV_N; i++) begin
				rem_q[i+1] <= rem_d[i];
				dv_q[i+1]  <= dv_q[i];
				qb_q[i+1]  <= qb_d[i];
				ovf_q[i+1] <= ovf_q[i];
			end

			sh_q <= SHADE_BASE + qfin;
		end
	end

	a_shade_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_shade >= SHADE_BASE && out_shade <= SHADE_BASE + SHADE_SPAN))
		else $error("shade out of range");
	a_degenerate: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[NB-1] && ctx_q[NB-1].deg) |-> out_shade == SHADE_BASE)
		else $error("degenerate triangle not at base shade");

endmodule

// File: hdl/triangle_view_projection_shading.sv
// channel  | dir | handshake           | payload
// s_axis   | in  | s_tvalid / s_tready | s_tdata: one triangle
// m_axis   | out | m_tvalid / m_tready | m_tdata: projected vertices, depth, shade
// apb      | in  | psel/penable/pready | four Q2.14 trig registers at 0x0..0xC
//
// One triangle per cycle sustained while the output is not stalled; a triangle passes
// the projection front, the queue and the shading back (which holds the square root).
// Reset clears the valid bits, the queue pointers and loads a straight-on view.
// An output stall freezes the back; the 4-deep queue absorbs the front until full.
module triangle_view_projection_shading import tvps_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// ax, ay, az, bx, by, bz, cx, cy, cz (16 bits each)
	input  logic [143:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// screen_u_a, screen_v_a, screen_u_b, screen_v_b, screen_u_c, screen_v_c,
	// mean_depth (17 bits each), shade (16 bits), one zero pad bit
	output logic [135:0] m_tdata,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	trig_t              trig_q;
	logic               wr;
	logic [REG_W-1:0]   rd_sel;
	logic               push, full, empty, pop, bk_ready;
	tri_t               fq_in, fq_out;
	pay_t               pay;
	logic [SHADE_W-1:0] shade;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_q.ca <= 16'sd16384;
			trig_q.sa <= '0;
			trig_q.ce <= 16'sd16384;
			trig_q.se <= '0;
		end else if (wr) begin
			case (paddr[3:2])
				REG_COS_AZ: trig_q.ca <= pwdata[REG_W-1:0];
				REG_SIN_AZ: trig_q.sa <= pwdata[REG_W-1:0];
				REG_COS_EL: trig_q.ce <= pwdata[REG_W-1:0];
				REG_SIN_EL: trig_q.se <= pwdata[REG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_COS_AZ: rd_sel = trig_q.ca;
			REG_SIN_AZ: rd_sel = trig_q.sa;
			REG_COS_EL: rd_sel = trig_q.ce;
			REG_SIN_EL: rd_sel = trig_q.se;
			default:    rd_sel = '0;
		endcase
		prdata = 32'($signed(rd_sel));
	end

	tvps_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.trig     (trig_q),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.crd      (s_tdata),
		.push     (push),
		.full     (full),
		.tri_out  (fq_in)
	);

	tvps_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (fq_in),
		.full   (full),
		.pop    (pop),
		.rdata  (fq_out),
		.empty  (empty)
	);

	assign pop = bk_ready && !empty;

	tvps_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (!empty),
		.in_ready  (bk_ready),
		.in_tri    (fq_out),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_pay   (pay),
		.out_shade (shade)
	);

	assign m_tdata = {1'b0, shade, pay.mean, pay.v[2], pay.u[2], pay.v[1], pay.u[1],
		pay.v[0], pay.u[0]};

endmodule

// File: tb/sv/tb_triangle_view_projection_shading.sv
module tb_triangle_view_projection_shading import tvps_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT = 1000000;
	localparam int N_RAND = 1750;

	// first member in the top bits, so u_a lands in the lowest bits
	typedef struct packed {
		logic [15:0] shade;
		logic [16:0] mean, v_c, u_c, v_b, u_b, v_a, u_a;
	} proj_t;

	typedef struct {
		logic [143:0] coords;
		logic         has_fixed;
		logic [15:0]  shade_fixed;
	} row_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [143:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [135:0] m_tdata;
	logic         psel = 1'b0;
	logic         penable = 1'b0;
	logic         pwrite = 1'b0;
	logic [3:0]   paddr = '0;
	logic [31:0]  pwdata = '0;
	logic [31:0]  prdata;
	logic         pready;

	logic signed [63:0] trig_ca, trig_sa, trig_ce, trig_se;
	proj_t expected_q[$];
	int    errors = 0;
	int    cycles = 0;
	bit    sink_on = 1'b0;

	triangle_view_projection_shading u_top (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic logic signed [63:0] rshift_round(input logic signed [63:0] s);
		logic [63:0] m;
		m = s < 0 ? -s : s;
		m = (m + 64'd8192) >> 14;
		return s < 0 ? -$signed(m) : $signed(m);
	endfunction

	function automatic logic [16:0] clamp17(input logic signed [63:0] s);
		if (s > 65535) return 17'h0ffff;
		if (s < -65536) return 17'h10000;
		return s[16:0];
	endfunction

	function automatic logic [63:0] sqrt_floor(input logic [63:0] n);
		logic [63:0] res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic logic [15:0] face_shade(input logic signed [63:0] p[9]);
		logic signed [63:0] e1x, e1y, e1z, e2x, e2y, e2z, num;
		logic signed [63:0] n[3], w[3];
		logic [63:0] mg[3], m, n2, den, q, an;
		e1x = p[3] - p[0]; e1y = p[4] - p[1]; e1z = p[5] - p[2];
		e2x = p[6] - p[0]; e2y = p[7] - p[1]; e2z = p[8] - p[2];
		n[0] = e1y * e2z - e1z * e2y;
		n[1] = e1z * e2x - e1x * e2z;
		n[2] = e1x * e2y - e1y * e2x;
		for (int i = 0; i < 3; i++) mg[i] = n[i] < 0 ? -n[i] : n[i];
		m = mg[0];
		if (mg[1] > m) m = mg[1];
		if (mg[2] > m) m = mg[2];
		if (m == 0) return 16'd8192;
		while (m >= (64'd1 << 30)) begin
			m >>= 1;
			for (int i = 0; i < 3; i++) mg[i] >>= 1;
		end
		while (m < (64'd1 << 29)) begin
			m <<= 1;
			for (int i = 0; i < 3; i++) mg[i] <<= 1;
		end
		for (int i = 0; i < 3; i++) n[i] = n[i] < 0 ? -$signed(mg[i]) : $signed(mg[i]);
		w[0] = rshift_round(trig_ca * trig_ce);
		w[1] = rshift_round(trig_sa * trig_ce);
		w[2] = trig_se;
		num = n[0] * w[0] + n[1] * w[1] + n[2] * w[2];
		n2 = mg[0] * mg[0] + mg[1] * mg[1] + mg[2] * mg[2];
		den = sqrt_floor(n2) << 14;
		an = num < 0 ? -num : num;
		q = (2 * 24576 * an + den) / (2 * den);
		if (q > 24576) q = 24576;
		return 16'(8192 + q);
	endfunction

	function automatic proj_t project_triangle(input logic [143:0] d);
		logic signed [63:0] p[9];
		logic signed [63:0] x, y, z, t, u, v, dp, dsum;
		logic [63:0] dm;
		logic [16:0] uv[6];
		proj_t r;
		dsum = 0;
		for (int k = 0; k < 9; k++) p[k] = $signed(d[16*k +: 16]);
		for (int k = 0; k < 3; k++) begin
			x = p[3*k]; y = p[3*k+1]; z = p[3*k+2];
			t = rshift_round(x * trig_ca + y * trig_sa);
			u = rshift_round(y * trig_ca - x * trig_sa);
			v = rshift_round(z * trig_ce - t * trig_se);
			dp = rshift_round(t * trig_ce + z * trig_se);
			uv[2*k] = clamp17(u);
			uv[2*k+1] = clamp17(v);
			dsum += dp;
		end
		dm = (2 * (dsum < 0 ? -dsum : dsum) + 3) / 6;
		r.u_a = uv[0]; r.v_a = uv[1]; r.u_b = uv[2];
		r.v_b = uv[3]; r.u_c = uv[4]; r.v_c = uv[5];
		r.mean = clamp17(dsum < 0 ? -$signed(dm) : $signed(dm));
		r.shade = face_shade(p);
		return r;
	endfunction

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		@(posedge clk);
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
		paddr <= {idx, 2'b00}; pwdata <= {{16{val[15]}}, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			REG_COS_AZ: trig_ca = $signed(val);
			REG_SIN_AZ: trig_sa = $signed(val);
			REG_COS_EL: trig_ce = $signed(val);
			REG_SIN_EL: trig_se = $signed(val);
			default: ;
		endcase
	endtask

	task automatic set_view(input logic [15:0] ca, sa, ce, se);
		s_tvalid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		write_reg(REG_COS_AZ, ca);
		write_reg(REG_SIN_AZ, sa);
		write_reg(REG_COS_EL, ce);
		write_reg(REG_SIN_EL, se);
	endtask

	// rows with a typed-in shade are checked against that value
	task automatic send_triangle(input logic [143:0] d, input logic has_fixed,
			input logic [15:0] fixed_shade);
		proj_t e;
		int    n;
		n = $urandom_range(0, 14);
		if (n != 0) begin
			s_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		e = project_triangle(d);
		if (has_fixed)
			e.shade = fixed_shade;
		expected_q = {expected_q, e};
		s_tdata <= d;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
	endtask

	// sink: idle a drawn number of cycles, then ready until one beat
	initial begin
		int n;
		wait (sink_on);
		forever begin
			n = $urandom_range(0, 14);
			if (n != 0) begin
				m_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	always @(posedge clk) begin
		proj_t got, e;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[134:0];
			if (expected_q.size() == 0) begin
				$error("result beat with nothing expected");
				errors++;
			end else begin
				e = expected_q.pop_front();
				if (got.u_a != e.u_a) begin $error("screen_u_a exp %h got %h", e.u_a, got.u_a); errors++; end
				if (got.v_a != e.v_a) begin $error("screen_v_a exp %h got %h", e.v_a, got.v_a); errors++; end
				if (got.u_b != e.u_b) begin $error("screen_u_b exp %h got %h", e.u_b, got.u_b); errors++; end
				if (got.v_b != e.v_b) begin $error("screen_v_b exp %h got %h", e.v_b, got.v_b); errors++; end
				if (got.u_c != e.u_c) begin $error("screen_u_c exp %h got %h", e.u_c, got.u_c); errors++; end
				if (got.v_c != e.v_c) begin $error("screen_v_c exp %h got %h", e.v_c, got.v_c); errors++; end
				if (got.mean != e.mean) begin $error("mean_depth exp %h got %h", e.mean, got.mean); errors++; end
				if (got.shade != e.shade) begin $error("shade exp %0d got %0d", e.shade, got.shade); errors++; end
			end
		end
	end

	function automatic logic [143:0] tri_pack(input int v[9]);
		logic [143:0] d;
		for (int k = 0; k < 9; k++) d[16*k +: 16] = 16'(v[k]);
		return d;
	endfunction

	function automatic logic [15:0] rand_coord(input int mode);
		case (mode)
			0: return 16'($urandom);
			1: return 16'($signed($urandom_range(0, 400)) - 200);
			2: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
			default: return 16'($signed($urandom_range(0, 8000)) - 4000);
		endcase
	endfunction

	initial begin
		row_t table_rows[$];
		row_t row;
		logic [143:0] d;
		int mode;
		logic [15:0] cs[5];
		trig_ca = 16384; trig_sa = 0; trig_ce = 16384; trig_se = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		sink_on = 1'b1;
		// degenerate: all zero, collinear, repeated vertex -> base shade
		row = '{tri_pack('{0,0,0,0,0,0,0,0,0}), 1'b1, 16'd8192}; table_rows = {table_rows, row};
		row = '{tri_pack('{1,2,3,2,4,6,3,6,9}), 1'b1, 16'd8192}; table_rows = {table_rows, row};
		row = '{tri_pack('{5,5,5,5,5,5,9,1,2}), 1'b1, 16'd8192}; table_rows = {table_rows, row};
		// triangle facing x at straight-on view -> full shade
		row = '{tri_pack('{0,0,0,0,100,0,0,0,100}), 1'b1, 16'd32768};
		table_rows = {table_rows, row};
		// normal along z, view along x -> base shade
		row = '{tri_pack('{0,0,0,100,0,0,0,100,0}), 1'b1, 16'd8192};
		table_rows = {table_rows, row};
		row = '{tri_pack('{32767,32767,32767,32767,32767,32767,32767,32767,32767}),
			1'b0, 16'd0};
		table_rows = {table_rows, row};
		row = '{tri_pack('{-32768,-32768,-32768,-32768,-32768,-32768,-32768,-32768,-32768}),
			1'b0, 16'd0};
		table_rows = {table_rows, row};
		row = '{tri_pack('{-32768,32767,-32768,32767,-32768,32767,-32768,32767,-32768}),
			1'b0, 16'd0};
		table_rows = {table_rows, row};
		row = '{tri_pack('{32767,-32768,0,-32768,0,32767,0,32767,-32768}), 1'b0, 16'd0};
		table_rows = {table_rows, row};
		row = '{tri_pack('{1,-1,1,-1,1,-1,1,1,-1}), 1'b0, 16'd0}; table_rows = {table_rows, row};
		foreach (table_rows[i])
			send_triangle(table_rows[i].coords, table_rows[i].has_fixed, table_rows[i].shade_fixed);

		// out-of-range registers, saturating extremes
		set_view(16'h8000, 16'h8000, 16'h8000, 16'h8000);
		for (int i = 0; i < 5; i++) send_triangle(tri_pack('{32767,-32768,32767,
			-32768,32767,-32768,1,2,i}), 1'b0, 16'd0);
		set_view(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
		for (int i = 0; i < 5; i++) send_triangle(tri_pack('{-32768,-32768,32767,
			32767,32767,-32768,i,0,3}), 1'b0, 16'd0);
		set_view(16'd11585, 16'd11585, 16'd11585, 16'd11585);
		for (int i = 0; i < 4; i++)
			send_triangle(tri_pack('{0,0,0,1000,0,0,0,1000,1000}), 1'b0, 16'd0);

		cs = '{16'd16384, 16'hc000, 16'd0, 16'd11585, 16'hd2bf};
		for (int ph = 0; ph < 7; ph++) begin
			if (ph < 5)
				set_view(cs[ph], cs[(ph + 2) % 5], cs[(ph + 3) % 5], cs[(ph + 1) % 5]);
			else
				set_view(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
			for (int i = 0; i < N_RAND / 7; i++) begin
				mode = $urandom_range(0, 3);
				for (int k = 0; k < 9; k++) d[16*k +: 16] = rand_coord(mode);
				if ($urandom_range(0, 19) == 0) d[143:96] = d[47:0];
				send_triangle(d, 1'b0, 16'd0);
			end
		end

		s_tvalid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// File: triangle_view_projection_shading.f
hdl/tvps_pkg.sv
hdl/tvps_front.sv
hdl/tvps_fifo.sv
hdl/tvps_back.sv
hdl/triangle_view_projection_shading.sv
tb/sv/tb_triangle_view_projection_shading.sv
